// ===== rtl/core/sdff_pkg.sv =====
// Shared widths, defaults and character codes of the signed decimal field formatter.
package sdff_pkg;

	localparam int VALUE_W      = 32;
	localparam int CNT_W        = 7;
	localparam int CHAR_W       = 8;
	localparam int NUM_DIGITS   = 10;
	localparam int DIGIT_W      = 4;
	localparam int BIT_CNT_W    = $clog2(VALUE_W);
	localparam int MAX_FIELD_DEF = 64;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

endpackage

// ===== rtl/core/signed_decimal_field_formatter_core.sv =====
// Top level of the signed decimal field formatter: bit-serial conversion and character emitter.
// Items are taken one at a time: in_stall stays high from the accepting edge until the last character
// of an item (1 to MAX_FIELD characters) is loaded into the output register. The work is the bit-serial
// binary-to-BCD conversion (one magnitude bit per cycle), the PREP, SETUP and LAYOUT states, then the
// one-character-per-cycle emitter, which holds while a pending character is stalled by out_stall.
// Reset: arst_n clears the sequencer and the output valid flag at once; no memory to clear.
module signed_decimal_field_formatter_core #(
	parameter int MAX_FIELD = sdff_pkg::MAX_FIELD_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [sdff_pkg::VALUE_W-1:0]  value,
	input  logic        [sdff_pkg::CNT_W-1:0]    field_width,
	input  logic signed [sdff_pkg::CNT_W-1:0]    min_digits,
	input  logic                                 left_justify,
	input  logic                                 zero_fill,
	input  logic                                 force_plus,
	input  logic                                 space_sign,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [sdff_pkg::CHAR_W-1:0]   ascii_char,
	output logic                                 last_char
);
	import sdff_pkg::*;

	localparam int CW = $clog2(MAX_FIELD + 1);
	localparam logic [CNT_W-1:0] MAXF = CNT_W'(MAX_FIELD);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_PREP,
		S_SETUP,
		S_LAYOUT,
		S_EMIT
	} state_t;

	state_t                               state_q;
	logic [VALUE_W-1:0]                   mag_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   bcd_q;
	logic [BIT_CNT_W-1:0]                 bit_q;
	logic                                 left_q;
	logic                                 zero_q;
	logic                                 given_q;
	logic [CNT_W-1:0]                     prec_q;
	logic [CNT_W-1:0]                     width_q;
	logic [CNT_W-1:0]                     wsat_q;
	logic [CHAR_W-1:0]                    sign_q;
	logic                                 signlen_q;
	logic [DIGIT_W-1:0]                   ndig_q;
	logic [CNT_W-1:0]                     digits_q;
	logic [CW-1:0]                        b1_q, b2_q, b3_q, b4_q, tot_q, pos_q;
	logic [DIGIT_W-1:0]                   didx_q;
	logic                                 ov_q;
	logic [CHAR_W-1:0]                    char_q;
	logic                                 last_q;

	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   adj;
	logic [DIGIT_W-1:0]                   ndig_c;
	logic [VALUE_W-1:0]                   value_u;
	logic [CNT_W-1:0]                     sl7, nd7, d0, d1, lim, d2, body, pad, b1;
	logic                                 zeropad;
	logic                                 load;
	logic                                 in_digits;
	logic [CHAR_W-1:0]                    char_c;

	assign value_u = value;

	// Double-dabble correction: every BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= DIGIT_W'(5)) ? bcd_q[i] + DIGIT_W'(3) : bcd_q[i];
		end
	end

	always_comb begin
		ndig_c = DIGIT_W'(1);
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				ndig_c = DIGIT_W'(i + 1);
			end
		end
	end

	// Digit count: precision, then zero padding to the width, then the field limit.
	always_comb begin
		sl7     = {{(CNT_W-1){1'b0}}, signlen_q};
		nd7     = {{(CNT_W-DIGIT_W){1'b0}}, ndig_q};
		d0      = (given_q && prec_q > nd7) ? prec_q : nd7;
		zeropad = zero_q && !given_q && !left_q;
		d1      = (zeropad && wsat_q > d0 + sl7) ? wsat_q - sl7 : d0;
		lim     = MAXF - sl7;
		d2      = (d1 > lim) ? lim : d1;
		body    = sl7 + digits_q;
		pad     = (wsat_q > body) ? wsat_q - body : '0;
		b1      = left_q ? '0 : pad;
	end

	always_comb begin
		in_digits = 1'b0;
		if (pos_q < b1_q) begin
			char_c = CH_SPACE;
		end else if (pos_q < b2_q) begin
			char_c = sign_q;
		end else if (pos_q < b3_q) begin
			char_c = CH_ZERO;
		end else if (pos_q < b4_q) begin
			char_c    = CH_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, bcd_q[didx_q]};
			in_digits = 1'b1;
		end else begin
			char_c = CH_SPACE;
		end
	end

	assign load     = (state_q == S_EMIT) && (!ov_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall && !load) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mag_q     <= value_u[VALUE_W-1] ? VALUE_W'(0) - value_u : value_u;
						bcd_q     <= '0;
						bit_q     <= '0;
						width_q   <= field_width;
						given_q   <= !min_digits[CNT_W-1];
						prec_q    <= min_digits;
						left_q    <= left_justify;
						zero_q    <= zero_fill;
						signlen_q <= value_u[VALUE_W-1] || force_plus || space_sign;
						if (value_u[VALUE_W-1]) begin
							sign_q <= CH_MINUS;
						end else if (force_plus) begin
							sign_q <= CH_PLUS;
						end else begin
							sign_q <= CH_SPACE;
						end
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					// The top digit never exceeds two, so its top bit is free to drop.
					bcd_q <= {adj[NUM_DIGITS-1][DIGIT_W-2:0], adj[NUM_DIGITS-2:0],
						mag_q[VALUE_W-1]};
					mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
					bit_q <= bit_q + BIT_CNT_W'(1);
					if (bit_q == BIT_CNT_W'(VALUE_W - 1)) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					ndig_q  <= ndig_c;
					wsat_q  <= (width_q > MAXF) ? MAXF : width_q;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					digits_q <= d2;
					state_q  <= S_LAYOUT;
				end
				S_LAYOUT: begin
					b1_q    <= CW'(b1);
					b2_q    <= CW'(b1 + sl7);
					b3_q    <= CW'(b1 + sl7 + (digits_q - nd7));
					b4_q    <= CW'(b1 + body);
					tot_q   <= CW'(body + pad);
					pos_q   <= '0;
					didx_q  <= ndig_q - DIGIT_W'(1);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load) begin
						ov_q   <= 1'b1;
						char_q <= char_c;
						last_q <= (pos_q + CW'(1)) == tot_q;
						pos_q  <= pos_q + CW'(1);
						if (in_digits) begin
							didx_q <= didx_q - DIGIT_W'(1);
						end
						if ((pos_q + CW'(1)) == tot_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

endmodule

// ===== rtl/core/sdff_checker.sv =====
// Port-level checker of the signed decimal field formatter and its bind to the top level.
module sdff_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sdff_pkg::CHAR_W-1:0]   ascii_char,
	input logic                          last_char
);
	import sdff_pkg::*;

	// A stalled output transaction holds its character and end mark.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ascii_char) && $stable(last_char))
		else $error("stalled output transaction changed");

	// Once an item is taken, the block is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an accepted transaction");

	// The block only frees its input after the final character has been produced.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid && last_char)
		else $error("input freed without a final character pending");

	// Only sign, space and decimal digit characters ever appear.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ascii_char == CH_SPACE || ascii_char == CH_PLUS
			|| ascii_char == CH_MINUS || (ascii_char >= CH_ZERO && ascii_char <= CH_NINE))
		else $error("unexpected output character");

endmodule

bind signed_decimal_field_formatter_core sdff_checker u_sdff_checker (.*);

// ===== bench/tb_signed_decimal_field_formatter_core.sv =====
// Self-checking testbench for the signed decimal field formatter core.
`timescale 1ns / 100ps

module tb_signed_decimal_field_formatter_core;
	import sdff_pkg::*;

	localparam int MAX_FIELD   = MAX_FIELD_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int END_WAIT    = 60;
	localparam int REPORT_CAP  = 50;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [CNT_W-1:0]          field_width;
		logic signed [CNT_W-1:0]   min_digits;
		bit                        left_justify;
		bit                        zero_fill;
		bit                        force_plus;
		bit                        space_sign;
		bit                        drain_first;
	} fmt_request_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} fmt_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_W-1:0] value = '0;
	logic [CNT_W-1:0] field_width = '0;
	logic signed [CNT_W-1:0] min_digits = '0;
	logic left_justify = 1'b0;
	logic zero_fill = 1'b0;
	logic force_plus = 1'b0;
	logic space_sign = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CHAR_W-1:0] ascii_char;
	logic last_char;

	fmt_request_t format_requests[$];
	fmt_char_t expected_chars[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	signed_decimal_field_formatter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.field_width(field_width),
		.min_digits(min_digits),
		.left_justify(left_justify),
		.zero_fill(zero_fill),
		.force_plus(force_plus),
		.space_sign(space_sign),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ascii_char(ascii_char),
		.last_char(last_char)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < REPORT_CAP) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Appends the characters of one conversion to the expected stream.
	function automatic void format_decimal_field(input fmt_request_t req);
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0] sign_ch;
		logic [CHAR_W-1:0] rev_digits [NUM_DIGITS];
		logic [CHAR_W-1:0] text [$];
		bit has_sign;
		bit zero_pad;
		int width;
		int prec;
		int sign_len;
		int ndig;
		int digits;
		int i;
		fmt_char_t c;

		mag = req.value;
		if (req.value[VALUE_W-1]) mag = '0 - mag;
		has_sign = 1'b1;
		if (req.value[VALUE_W-1]) sign_ch = CH_MINUS;
		else if (req.force_plus) sign_ch = CH_PLUS;
		else if (req.space_sign) sign_ch = CH_SPACE;
		else has_sign = 1'b0;
		sign_len = has_sign ? 1 : 0;

		ndig = 0;
		do begin
			rev_digits[ndig] = CH_ZERO + CHAR_W'(mag % 10);
			mag = mag / 10;
			ndig++;
		end while (mag != 0 && ndig < NUM_DIGITS);

		width = int'(req.field_width);
		if (width > MAX_FIELD) width = MAX_FIELD;
		// Any negative precision counts as absent.
		prec = req.min_digits[CNT_W-1] ? -1 : int'(req.min_digits[CNT_W-2:0]);

		digits = ndig;
		if (prec > digits) digits = prec;
		zero_pad = req.zero_fill && prec < 0 && !req.left_justify;
		if (zero_pad && width - sign_len > digits) digits = width - sign_len;
		if (digits > MAX_FIELD - sign_len) digits = MAX_FIELD - sign_len;

		if (!req.left_justify)
			for (i = sign_len + digits; i < width; i++) text.push_back(CH_SPACE);
		if (has_sign) text.push_back(sign_ch);
		for (i = ndig; i < digits; i++) text.push_back(CH_ZERO);
		for (i = ndig - 1; i >= 0; i--) text.push_back(rev_digits[i]);
		if (req.left_justify)
			for (i = sign_len + digits; i < width; i++) text.push_back(CH_SPACE);

		while (text.size() > MAX_FIELD) void'(text.pop_back());
		for (i = 0; i < text.size(); i++) begin
			c.ch = text[i];
			c.last = (i == text.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic fmt_request_t make_request(input logic signed [VALUE_W-1:0] v,
			input int w, input int p, input bit l, input bit z, input bit pl, input bit sp);
		fmt_request_t req;
		req.value = v;
		req.field_width = CNT_W'(w);
		req.min_digits = CNT_W'(p);
		req.left_justify = l;
		req.zero_fill = z;
		req.force_plus = pl;
		req.space_sign = sp;
		req.drain_first = 1'b0;
		return req;
	endfunction

	function automatic fmt_request_t random_request();
		logic signed [VALUE_W-1:0] v;
		int w;
		int p;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: begin
				v = $urandom_range(0, 99999);
				if ($urandom_range(0, 1)) v = -v;
			end
			2: v = 32'sh8000_0000 + $urandom_range(0, 3);
			3: v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
			default: v = $urandom_range(0, 1) ? 0 : -$urandom_range(1, 9);
		endcase
		case ($urandom_range(0, 9))
			0: w = $urandom_range(65, 127);
			1, 2: w = $urandom_range(16, 64);
			default: w = $urandom_range(0, 15);
		endcase
		case ($urandom_range(0, 9))
			0: p = $urandom_range(0, 127);
			1: p = $urandom_range(13, 63);
			2, 3, 4: p = $urandom_range(0, 12);
			default: p = -1;
		endcase
		return make_request(v, w, p, $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 1), $urandom_range(0, 1));
	endfunction

	task automatic wait_all_accepted();
		while (format_requests.size() != 0) @(posedge clk);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n,
			input bit drain);
		fmt_request_t req;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n; k++) begin
			req = random_request();
			req.drain_first = drain && k == 0;
			format_requests.push_back(req);
		end
		wait_all_accepted();
	endtask

	// Input side: a transaction stays on the port until it is taken.
	always @(posedge clk) begin : drive_requests
		bit present;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				format_decimal_field(format_requests.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				present = 1'b0;
				if (format_requests.size() != 0) begin
					present = $urandom_range(0, 99) >= send_idle_pct;
					if (format_requests[0].drain_first && expected_chars.size() != 0)
						present = 1'b0;
				end
				in_valid <= present;
				if (present) begin
					value <= format_requests[0].value;
					field_width <= format_requests[0].field_width;
					min_digits <= format_requests[0].min_digits;
					left_justify <= format_requests[0].left_justify;
					zero_fill <= format_requests[0].zero_fill;
					force_plus <= format_requests[0].force_plus;
					space_sign <= format_requests[0].space_sign;
				end
			end
		end
	end

	// Output side: checks each character against the oldest expectation.
	always @(posedge clk) begin : check_chars
		fmt_char_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %h, no transaction pending",
						ascii_char));
				end else begin
					want = expected_chars.pop_front();
					if (ascii_char !== want.ch)
						report_mismatch($sformatf("ascii_char %h, expected %h", ascii_char,
							want.ch));
					if (last_char !== want.last)
						report_mismatch($sformatf("last_char %b, expected %b on %h", last_char,
							want.last, want.ch));
				end
			end
			out_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases: zero, extremes, sign flags, padding modes and saturation.
		format_requests.push_back(make_request(0, 0, -1, 0, 0, 0, 0));
		format_requests.push_back(make_request(0, 0, 0, 0, 0, 0, 0));
		format_requests.push_back(make_request(32'sh8000_0000, 0, -1, 0, 0, 0, 0));
		format_requests.push_back(make_request(32'sh7FFF_FFFF, 0, -1, 0, 0, 1, 0));
		format_requests.push_back(make_request(123, 0, -1, 0, 0, 0, 1));
		format_requests.push_back(make_request(123, 0, -1, 0, 0, 1, 1));
		format_requests.push_back(make_request(-42, 8, -1, 0, 1, 0, 0));
		format_requests.push_back(make_request(-42, 8, 5, 0, 1, 0, 0));
		format_requests.push_back(make_request(42, 8, -1, 1, 1, 0, 0));
		format_requests.push_back(make_request(7, 64, -1, 0, 0, 0, 0));
		format_requests.push_back(make_request(-7, 127, -1, 1, 0, 0, 0));
		format_requests.push_back(make_request(5, 0, 63, 0, 0, 1, 0));
		format_requests.push_back(make_request(-5, 64, 63, 0, 1, 0, 0));
		format_requests.push_back(make_request(99, 10, -64, 0, 1, 0, 0));
		format_requests.push_back(make_request(99, 5, -2, 0, 0, 0, 0));
		format_requests.push_back(make_request(1234567890, 12, -1, 1, 0, 0, 1));
		format_requests.push_back(make_request(-1, 3, -1, 0, 0, 0, 0));
		format_requests.push_back(make_request(0, 64, -1, 0, 1, 1, 0));
		format_requests.push_back(make_request(1000000000, 0, 12, 0, 0, 0, 0));
		format_requests.push_back(make_request(0, 0, 63, 0, 0, 0, 1));
		format_requests.push_back(make_request(32'sh5555_5555, 64, 42, 1, 0, 0, 0));
		format_requests.push_back(make_request(-32'sh2AAA_AAAA, 127, -1, 0, 1, 0, 0));
		wait_all_accepted();

		run_random_phase(0, 0, 25, 1'b0);
		run_random_phase(81, 0, 20, 1'b1);
		run_random_phase(0, 81, 20, 1'b0);
		run_random_phase(8, 8, 25, 1'b1);

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
